[rtl/crc_pdu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the CRC polynomial divider.
package crc_pdu_pkg;

	localparam int GEN_WIDTH_DEF = 16;
	localparam int REM_WIDTH     = 16;
	localparam int CFG_WIDTH     = 16;
	localparam int DEG_WIDTH     = 4;
	localparam int IDX_WIDTH     = 2;
	localparam int CNT_WIDTH     = 5;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;
	typedef logic [IDX_WIDTH-1:0] reg_idx_t;

	localparam kind_t KIND_QUOT   = 2'd0;
	localparam kind_t KIND_REM    = 2'd1;
	localparam kind_t KIND_STATUS = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ERROR    = 2'd1;
	localparam status_t ST_IMPROPER = 2'd2;

	localparam reg_idx_t REG_GENERATOR  = 2'd0;
	localparam reg_idx_t REG_DEGREE     = 2'd1;
	localparam reg_idx_t REG_CHECK_MODE = 2'd2;

	typedef struct packed {
		logic shift;
		logic clear;
		logic xor_en;
	} cell_ctl_t;

endpackage

[rtl/crc_pdu_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame bits and result words.
interface crc_pdu_frame_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic frame_end;

	modport source (output valid, output data_bit, output frame_end, input ready);
	modport sink (input valid, input data_bit, input frame_end, output ready);
endinterface

interface crc_pdu_result_if;
	logic                  valid;
	logic                  ready;
	crc_pdu_pkg::kind_t    kind;
	logic                  bit_value;
	crc_pdu_pkg::status_t  status;
	logic                  last;

	modport source (output valid, output kind, output bit_value, output status,
		output last, input ready);
	modport sink (input valid, input kind, input bit_value, input status,
		input last, output ready);
endinterface

[rtl/crc_polynomial_divider_unit.sv]
`timescale 1ns / 1ps
// Top level: bit-serial CRC divider built from a chain of remainder cells.
//
//   channel   dir   width           word
//   frame     in    1+1             data_bit, frame_end
//   result    out   2+1+2+1         kind, bit_value, status, last
//   wr_*      in    1+2+16          register write: enable, index, data
//
// One frame bit is taken per cycle unless the output or a frame end stalls it;
// each yields at most one quotient word. After a proper final bit the block
// emits degree zero-fed quotient words (encode only), degree remainder words
// and one status word, one per cycle while the output register advances.
// A single output register separates the sides; it advances when empty or taken.
// Reset clears remainder cells, bit counter, generator, mode; degree becomes 1.
module crc_polynomial_divider_unit #(
	parameter int GEN_WIDTH = crc_pdu_pkg::GEN_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	crc_pdu_frame_if.sink                       frame,
	crc_pdu_result_if.source                    result,
	input  logic                                wr_en,
	input  crc_pdu_pkg::reg_idx_t               wr_index,
	input  logic [crc_pdu_pkg::CFG_WIDTH-1:0]   wr_data
);
	import crc_pdu_pkg::*;

	localparam int NCELL  = (GEN_WIDTH > REM_WIDTH) ? REM_WIDTH : GEN_WIDTH;
	localparam int IDXW   = $clog2(NCELL);
	localparam int MAXDEG = GEN_WIDTH - 1;

	localparam logic [1:0] S_RUN  = 2'd0;
	localparam logic [1:0] S_ENC  = 2'd1;
	localparam logic [1:0] S_REM  = 2'd2;
	localparam logic [1:0] S_STAT = 2'd3;

	logic [CFG_WIDTH-1:0] generator_q;
	logic [DEG_WIDTH-1:0] degree_q;
	logic                 check_mode_q;

	logic [1:0]           state_q, state_d;
	logic [DEG_WIDTH-1:0] cnt_q, cnt_d;
	logic                 err_q, err_d;
	logic [CNT_WIDTH-1:0] bits_seen_q, bits_seen_d, bs_inc;

	logic [NCELL-1:0] rem_q;
	logic [NCELL-1:0] shifted;
	logic [NCELL-1:0] keep;
	logic             shift_in;
	cell_ctl_t        ctl;

	logic    adv, take, proper, enough, deg_fits, q;
	logic    nv, nbit, nlast;
	kind_t   nkind;
	status_t nstat;

	logic    res_valid_q;
	kind_t   kind_q;
	logic    bit_value_q;
	status_t status_q;
	logic    last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generator_q  <= '0;
			degree_q     <= DEG_WIDTH'(1);
			check_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GENERATOR:  generator_q  <= wr_data;
				REG_DEGREE:     degree_q     <= wr_data[DEG_WIDTH-1:0];
				REG_CHECK_MODE: check_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign shifted  = {rem_q[NCELL-2:0], shift_in};
	assign deg_fits = int'(degree_q) < NCELL;
	assign q        = deg_fits ? shifted[degree_q[IDXW-1:0]] : 1'b0;
	assign proper   = (degree_q != '0) && (int'(degree_q) <= MAXDEG) &&
		generator_q[degree_q] && generator_q[0];
	assign bs_inc   = (bits_seen_q == CNT_WIDTH'(REM_WIDTH)) ? bits_seen_q
		: bits_seen_q + CNT_WIDTH'(1);
	assign enough   = bs_inc >= ({1'b0, degree_q} + CNT_WIDTH'(1));

	assign adv          = !res_valid_q || result.ready;
	assign frame.ready  = adv && (state_q == S_RUN);
	assign take         = frame.valid && frame.ready;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		assign keep[i] = CNT_WIDTH'(i) <= {1'b0, degree_q};
		crc_pdu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev_bit (shifted[i]),
			.gen_bit  (generator_q[i]),
			.keep     (keep[i]),
			.bit_q    (rem_q[i])
		);
	end

	always_comb begin
		ctl         = '0;
		shift_in    = 1'b0;
		nv          = 1'b0;
		nkind       = KIND_QUOT;
		nbit        = 1'b0;
		nstat       = ST_OK;
		nlast       = 1'b0;
		state_d     = state_q;
		cnt_d       = cnt_q;
		err_d       = err_q;
		bits_seen_d = bits_seen_q;
		unique case (state_q)
			S_RUN: begin
				if (take) begin
					shift_in    = frame.data_bit;
					ctl.shift   = 1'b1;
					ctl.xor_en  = proper && enough && q;
					bits_seen_d = bs_inc;
					if (frame.frame_end) begin
						nv = 1'b1;
						if (proper && enough) begin
							nbit    = q;
							cnt_d   = degree_q;
							state_d = check_mode_q ? S_REM : S_ENC;
						end else begin
							nkind       = KIND_STATUS;
							nstat       = ST_IMPROPER;
							nlast       = 1'b1;
							ctl.clear   = 1'b1;
							bits_seen_d = '0;
						end
					end else begin
						nv   = proper && enough;
						nbit = q;
					end
				end
			end
			S_ENC: begin
				if (adv) begin
					ctl.shift  = 1'b1;
					ctl.xor_en = q;
					nv         = 1'b1;
					nbit       = q;
					cnt_d      = cnt_q - DEG_WIDTH'(1);
					if (cnt_q == DEG_WIDTH'(1)) begin
						cnt_d   = degree_q;
						state_d = S_REM;
					end
				end
			end
			S_REM: begin
				if (adv) begin
					ctl.shift = 1'b1;
					nv        = 1'b1;
					nkind     = KIND_REM;
					nbit      = q;
					err_d     = err_q | q;
					cnt_d     = cnt_q - DEG_WIDTH'(1);
					if (cnt_q == DEG_WIDTH'(1)) begin
						state_d = S_STAT;
					end
				end
			end
			S_STAT: begin
				if (adv) begin
					nv          = 1'b1;
					nkind       = KIND_STATUS;
					nstat       = (check_mode_q && err_q) ? ST_ERROR : ST_OK;
					nlast       = 1'b1;
					ctl.clear   = 1'b1;
					bits_seen_d = '0;
					err_d       = 1'b0;
					state_d     = S_RUN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			bits_seen_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			err_q       <= err_d;
			bits_seen_q <= bits_seen_d;
			if (adv) begin
				res_valid_q <= nv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nv) begin
			kind_q      <= nkind;
			bit_value_q <= nbit;
			status_q    <= nstat;
			last_q      <= nlast;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.kind      = kind_q;
	assign result.bit_value = bit_value_q;
	assign result.status    = status_q;
	assign result.last      = last_q;

endmodule

[rtl/crc_pdu_cell.sv]
`timescale 1ns / 1ps
// One partial-remainder bit: shift from neighbor, conditional XOR, or clear.
module crc_pdu_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  crc_pdu_pkg::cell_ctl_t ctl,
	input  logic                   prev_bit,
	input  logic                   gen_bit,
	input  logic                   keep,
	output logic                   bit_q
);
	import crc_pdu_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.shift) begin
			bit_q <= keep & (prev_bit ^ (ctl.xor_en & gen_bit));
		end
	end

endmodule
